@@ hdl/fdsa_pkg.sv @@
package fdsa_pkg;

    localparam int SLOT_SPACE = 1024;
    localparam int SLOT_W     = 10;
    localparam int LIMIT_W    = 11;
    localparam int ROW_W      = 32;
    localparam int ROWS       = SLOT_SPACE / ROW_W;
    localparam int ROW_IDX_W  = 5;
    localparam int BIT_IDX_W  = 5;
    localparam int DESC_W     = 31;
    localparam int COOKIE_W   = 64;
    localparam int TYPE_W     = 2;
    localparam int STATUS_W   = 2;

    localparam int SLOTS_PER_SET_DEF = 64;
    localparam int MAX_SETS_DEF      = 16;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 112;
    localparam int M_TUSER_W = 3;

    typedef enum logic [TYPE_W-1:0] {
        REQ_ALLOC_ANY  = 2'd0,
        REQ_ALLOC_SLOT = 2'd1,
        REQ_FREE       = 2'd2
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_TAKEN     = 2'd1,
        STS_NOT_ALLOC = 2'd2,
        STS_FULL      = 2'd3
    } status_t;

    // Lowest clear bit of a row word; MSB of the result flags a hit.
    function automatic logic [ROW_IDX_W:0] first_zero(input logic [ROW_W-1:0] w);
        logic [ROW_IDX_W:0] r;
        r = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r = {1'b1, ROW_IDX_W'(i)};
            end
        end
        return r;
    endfunction

endpackage

@@ hdl/fd_slot_map_allocator.sv @@
// Descriptor slot allocator. Slots 0..1023 form sets of SLOTS_PER_SET slots,
// and sets are switched on in order only when an allocate-any request finds
// no free slot among the active ones (at most min(MAX_SETS, 1024 /
// SLOTS_PER_SET) sets). s_tuser carries the request kind: allocate the
// lowest free slot, claim a named slot, or free a named slot, which hands
// back the host descriptor and cookie stored at allocation. Each request
// gives exactly one result item. Used bits live in a 32 x 32 row memory;
// a row summary of full flags and per-row valid bits sit in flip-flops, so
// reset takes effect at once and there is no clearing pass. One first-zero
// encoder is shared: allocate-any uses it first on the full flags to pick a
// row, then on the row word to pick the slot. Allocate-any reads the row the
// full flags pick, other kinds the named row; then a read-modify-write step,
// then the output register load, which waits while an earlier result is held.
// The block takes one request at a time and accepts the next one once the
// previous result has moved into the output register, whether or not it has been taken.
module fd_slot_map_allocator #(
    parameter int SLOTS_PER_SET = fdsa_pkg::SLOTS_PER_SET_DEF,
    parameter int MAX_SETS      = fdsa_pkg::MAX_SETS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request item
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [9:0] slot_number, [40:10] host_descriptor, [104:41] cookie, rest zero
    input  logic [fdsa_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] req_type
    input  logic [fdsa_pkg::TYPE_W-1:0]     s_tuser,
    // result item
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [9:0] granted_slot, [40:10] freed_descriptor, [104:41] freed_cookie, rest zero
    output logic [fdsa_pkg::M_TDATA_W-1:0]  m_tdata,
    // [1:0] status, [2] entry_found
    output logic [fdsa_pkg::M_TUSER_W-1:0]  m_tuser
);

    localparam int SETS_BY_WIDTH = fdsa_pkg::SLOT_SPACE / SLOTS_PER_SET;
    localparam int USABLE_SETS   = (MAX_SETS < SETS_BY_WIDTH) ? MAX_SETS : SETS_BY_WIDTH;
    localparam int ACT_W         = $clog2(USABLE_SETS + 1);

    localparam int SW = fdsa_pkg::SLOT_W;
    localparam int RW = fdsa_pkg::ROW_W;
    localparam int RI = fdsa_pkg::ROW_IDX_W;
    localparam int BI = fdsa_pkg::BIT_IDX_W;
    localparam int DW = fdsa_pkg::DESC_W;
    localparam int CW = fdsa_pkg::COOKIE_W;
    localparam int LW = fdsa_pkg::LIMIT_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_SEND  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // request capture
    fdsa_pkg::req_type_t req_type_reg;
    logic [SW-1:0]       req_slot_reg;
    logic [DW-1:0]       req_desc_reg;
    logic [CW-1:0]       req_cookie_reg;

    // allocation region
    logic [ACT_W-1:0] active_reg;
    logic [LW-1:0]    limit_reg;    // active sets times set size

    // row summary and row memory of used bits
    logic [fdsa_pkg::ROWS-1:0] full_reg;
    logic [fdsa_pkg::ROWS-1:0] valid_reg;
    logic [RW-1:0]             used_mem [fdsa_pkg::ROWS];
    logic [RW-1:0]             used_q;
    logic [RI-1:0]             rd_row_reg;
    logic                      scan_none_reg;

    // stored descriptor and cookie per slot
    logic [DW-1:0] desc_mem   [fdsa_pkg::SLOT_SPACE];
    logic [CW-1:0] cookie_mem [fdsa_pkg::SLOT_SPACE];
    logic [DW-1:0] desc_q;
    logic [CW-1:0] cookie_q;

    // pending result and output register
    fdsa_pkg::status_t res_status_reg, res_status_next;
    logic [SW-1:0]     res_slot_reg, res_slot_next;
    logic              res_found_reg, res_found_next;
    logic [DW-1:0]     res_desc_reg, res_desc_next;
    logic [CW-1:0]     res_cookie_reg, res_cookie_next;

    logic                      m_tvalid_reg;
    fdsa_pkg::status_t         m_status_reg;
    logic [SW-1:0]             m_slot_reg;
    logic                      m_found_reg;
    logic [DW-1:0]             m_desc_reg;
    logic [CW-1:0]             m_cookie_reg;

    logic          s_accept;
    logic          row_re;
    logic [RI-1:0] row_raddr;
    logic [RW-1:0] row_word;
    logic [RW-1:0] fz_in;
    logic          fz_found;
    logic [BI-1:0] fz_idx;

    logic          row_we;
    logic [RW-1:0] row_wdata;
    logic          ent_we;
    logic [SW-1:0] ent_waddr;
    logic          activate;
    logic          can_act;
    logic          in_range;
    logic [SW-1:0] any_slot;
    logic [BI-1:0] req_bit;
    logic          out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // rows whose valid bit is clear have never been written and hold no used slot
    assign row_word = valid_reg[rd_row_reg] ? used_q : '0;

    // shared first-zero unit: full flags while scanning, row word afterwards
    assign fz_in = (state_reg == ST_SCAN) ? RW'(full_reg) : row_word;
    assign {fz_found, fz_idx} = fdsa_pkg::first_zero(fz_in);

    assign row_re    = s_accept || (state_reg == ST_SCAN);
    assign row_raddr = (state_reg == ST_SCAN) ? fz_idx : s_tdata[SW-1:BI];

    assign can_act  = active_reg < ACT_W'(USABLE_SETS);
    assign in_range = {1'b0, req_slot_reg} < limit_reg;
    assign req_bit  = req_slot_reg[BI-1:0];
    assign any_slot = {rd_row_reg, fz_idx};

    always_comb begin
        state_next      = state_reg;
        row_we          = 1'b0;
        row_wdata       = row_word;
        ent_we          = 1'b0;
        ent_waddr       = req_slot_reg;
        activate        = 1'b0;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_found_next  = res_found_reg;
        res_desc_next   = res_desc_reg;
        res_cookie_next = res_cookie_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (fdsa_pkg::req_type_t'(s_tuser) == fdsa_pkg::REQ_ALLOC_ANY) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_SCAN: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next      = ST_SEND;
                res_status_next = fdsa_pkg::STS_OK;
                res_slot_next   = req_slot_reg;
                res_found_next  = 1'b0;
                res_desc_next   = '0;
                res_cookie_next = '0;
                case (req_type_reg)
                    fdsa_pkg::REQ_ALLOC_ANY: begin
                        // the first clear bit is either a free active slot
                        // or the first slot of the next set
                        if (scan_none_reg || !fz_found) begin
                            res_status_next = fdsa_pkg::STS_FULL;
                            res_slot_next   = '0;
                        end else if (({1'b0, any_slot} < limit_reg) || can_act) begin
                            row_we        = 1'b1;
                            row_wdata     = row_word | (RW'(1) << fz_idx);
                            ent_we        = 1'b1;
                            ent_waddr     = any_slot;
                            activate      = ({1'b0, any_slot} >= limit_reg);
                            res_slot_next = any_slot;
                        end else begin
                            res_status_next = fdsa_pkg::STS_FULL;
                            res_slot_next   = '0;
                        end
                    end
                    fdsa_pkg::REQ_ALLOC_SLOT: begin
                        if (!in_range || row_word[req_bit]) begin
                            res_status_next = fdsa_pkg::STS_TAKEN;
                        end else begin
                            row_we    = 1'b1;
                            row_wdata = row_word | (RW'(1) << req_bit);
                            ent_we    = 1'b1;
                        end
                    end
                    fdsa_pkg::REQ_FREE: begin
                        if (in_range) begin
                            if (!row_word[req_bit]) begin
                                res_status_next = fdsa_pkg::STS_NOT_ALLOC;
                            end else begin
                                row_we          = 1'b1;
                                row_wdata       = row_word & ~(RW'(1) << req_bit);
                                res_found_next  = 1'b1;
                                res_desc_next   = desc_q;
                                res_cookie_next = cookie_q;
                            end
                        end
                    end
                    default: begin
                        res_status_next = fdsa_pkg::STS_TAKEN;
                        res_slot_next   = '0;
                    end
                endcase
            end
            ST_SEND: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            active_reg   <= '0;
            limit_reg    <= '0;
            full_reg     <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (activate) begin
                active_reg <= active_reg + ACT_W'(1);
                limit_reg  <= limit_reg + LW'(SLOTS_PER_SET);
            end
            if (row_we) begin
                full_reg[rd_row_reg]  <= &row_wdata;
                valid_reg[rd_row_reg] <= 1'b1;
            end
            if (state_reg == ST_SEND && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_type_reg   <= fdsa_pkg::req_type_t'(s_tuser);
            req_slot_reg   <= s_tdata[SW-1:0];
            req_desc_reg   <= s_tdata[SW+DW-1:SW];
            req_cookie_reg <= s_tdata[SW+DW+CW-1:SW+DW];
        end
        if (row_re) begin
            rd_row_reg <= row_raddr;
        end
        if (state_reg == ST_SCAN) begin
            scan_none_reg <= !fz_found;
        end
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_found_reg  <= res_found_next;
        res_desc_reg   <= res_desc_next;
        res_cookie_reg <= res_cookie_next;
        if (state_reg == ST_SEND && out_free) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_found_reg  <= res_found_reg;
            m_desc_reg   <= res_desc_reg;
            m_cookie_reg <= res_cookie_reg;
        end
    end

    // used-bit row memory
    always_ff @(posedge aclk) begin
        if (row_we) begin
            used_mem[rd_row_reg] <= row_wdata;
        end
        if (row_re) begin
            used_q <= used_mem[row_raddr];
        end
    end

    // descriptor and cookie memory
    always_ff @(posedge aclk) begin
        if (ent_we) begin
            desc_mem[ent_waddr]   <= req_desc_reg;
            cookie_mem[ent_waddr] <= req_cookie_reg;
        end
        if (s_accept) begin
            desc_q   <= desc_mem[s_tdata[SW-1:0]];
            cookie_q <= cookie_mem[s_tdata[SW-1:0]];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {m_found_reg, m_status_reg};
    assign m_tdata  = {(fdsa_pkg::M_TDATA_W - SW - DW - CW)'(0),
                       m_cookie_reg, m_desc_reg, m_slot_reg};

endmodule
